// ===== rtl/core/tilemap_sprite_emitter_macros.svh =====
// Assertion macros used by the port-level checker of the tile-map sprite emitter.
// No dependencies; take in by include with the bare file name.
`ifndef TILEMAP_SPRITE_EMITTER_MACROS_SVH
`define TILEMAP_SPRITE_EMITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define TSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tse_pkg.sv =====
// Types, codes and constants of the tile-map sprite emitter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tse_pkg;

   // stream word widths
   localparam int REQ_W      = 96;
   localparam int RSP_W      = 120;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_ACROSS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_DOWN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT  = 2'd3;

   // item kinds
   localparam logic FUNC_SET    = 1'b0;
   localparam logic FUNC_RENDER = 1'b1;

   // map entry: {flip_y, flip_x, index[12:0]}
   localparam int ENTRY_W = 15;
   localparam int IDX_W   = 13;
   localparam logic [ENTRY_W-1:0] ENTRY_EMPTY = 15'h1FFF;

   // walk counter holds 0..64
   localparam int WALK_W = 7;
   localparam int ADDR_W = 6;

   // shared multiplier
   localparam int MUL_A_W     = 12;
   localparam int MUL_B_W     = 16;
   localparam int MUL_P_W     = 28;
   localparam int RECIP_SHIFT = 15;

   // floor(2^15 / a) for a = 1..8; quotient estimate is low by at most one
   function automatic logic [MUL_B_W-1:0] recip(input logic [3:0] a);
      logic [MUL_B_W-1:0] m;
      case (a)
         4'd1:    m = 16'd32768;
         4'd2:    m = 16'd16384;
         4'd3:    m = 16'd10922;
         4'd4:    m = 16'd8192;
         4'd5:    m = 16'd6553;
         4'd6:    m = 16'd5461;
         4'd7:    m = 16'd4681;
         4'd8:    m = 16'd4096;
         default: m = 16'd32768;
      endcase
      return m;
   endfunction

   // effective configuration seen by the walker
   typedef struct packed {
      logic [3:0]        across;
      logic [WALK_W-1:0] walk_len;
      logic [7:0]        tile_w;
      logic [7:0]        tile_h;
   } tse_cfg_type;

   // command from the request side
   typedef struct packed {
      logic               start;
      logic signed [19:0] cam_x;
      logic signed [19:0] cam_y;
      logic [31:0]        color;
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
   } tse_cmd_type;

   // one sprite result
   typedef struct packed {
      logic [20:0] screen_x;
      logic [20:0] screen_y;
      logic [19:0] uv_x;
      logic [19:0] uv_y;
      logic        flip_x;
      logic        flip_y;
      logic [31:0] color;
      logic        last_tile;
   } tse_result_type;

endpackage

// ===== rtl/core/tse_store.sv =====
// Tile map store: one write port, one registered read port, per-entry valid bits.
// Depends on tse_pkg.
`timescale 1ns / 1ps

module tse_store
   import tse_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [WALK_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ENTRY_W-1:0] store_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [DEPTH-1:0]   valid_in;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_vld_ff;

   // valid bits: set on write, all clear at reset
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr[AW-1:0]] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr[AW-1:0]];
      rd_vld_ff  <= valid_ff[rd_addr[AW-1:0]];
   end

   // never-written entries read as empty
   assign rd_data = rd_vld_ff ? rd_data_ff : ENTRY_EMPTY;

endmodule

// ===== rtl/core/tse_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on tse_pkg.
`timescale 1ns / 1ps

module tse_mul
   import tse_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_A_W-1:0] op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic [MUL_P_W-1:0] prod
);

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/tse_walker.sv =====
// Render sequencer: walks the map, drives the shared multiplier, stages results.
// Depends on tse_pkg, tse_store and tse_mul.
`timescale 1ns / 1ps

module tse_walker
   import tse_pkg::*;
#(
   parameter int MAX_TILES = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  tse_cfg_type    cfg,
   input  tse_cmd_type    cmd,
   output logic           idle,
   input  logic           out_ready,
   output logic           out_valid,
   output tse_result_type out_word
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_MSX   = 4'd3;
   localparam logic [3:0] S_MSY   = 4'd4;
   localparam logic [3:0] S_MQE   = 4'd5;
   localparam logic [3:0] S_MQA   = 4'd6;
   localparam logic [3:0] S_MFIX  = 4'd7;
   localparam logic [3:0] S_MUX   = 4'd8;
   localparam logic [3:0] S_MUY   = 4'd9;
   localparam logic [3:0] S_MEND  = 4'd10;
   localparam logic [3:0] S_PUSH  = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]         state_ff, state_in;
   logic [WALK_W-1:0]  pos_ff, pos_in;
   logic [2:0]         col_ff, col_in;
   logic [2:0]         row_ff, row_in;
   logic [19:0]        cam_x_ff, cam_x_in;
   logic [19:0]        cam_y_ff, cam_y_in;
   logic [31:0]        color_ff, color_in;
   logic [11:0]        id_ff, id_in;
   logic               fx_ff, fx_in;
   logic               fy_ff, fy_in;
   logic [11:0]        q_ff, q_in;
   logic [2:0]         r_ff, r_in;
   tse_result_type     cur_ff, cur_in;
   tse_result_type     hold_ff, hold_in;
   logic               hold_vld_ff, hold_vld_in;
   tse_result_type     out_ff, out_in;
   logic               out_vld_ff, out_vld_in;

   logic [ENTRY_W-1:0] rd_data;
   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [MUL_P_W-1:0] prod;
   logic               out_free;
   logic               last_pos;
   logic [11:0]        r_raw;
   logic [11:0]        r_fix;
   logic [11:0]        q_est;

   tse_store #(.DEPTH(MAX_TILES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   tse_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign out_free = !out_vld_ff || out_ready;
   assign last_pos = (pos_ff == cfg.walk_len - WALK_W'(1));
   assign q_est    = prod[RECIP_SHIFT +: 12];
   assign r_raw    = id_ff - prod[11:0];
   assign r_fix    = r_raw - {8'd0, cfg.across};

   // multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_MSX: begin
            op_a = MUL_A_W'(col_ff);
            op_b = MUL_B_W'(cfg.tile_w);
         end
         S_MSY: begin
            op_a = MUL_A_W'(row_ff);
            op_b = MUL_B_W'(cfg.tile_h);
         end
         S_MQE: begin
            op_a = id_ff;
            op_b = recip(cfg.across);
         end
         S_MQA: begin
            op_a = q_est;
            op_b = MUL_B_W'(cfg.across);
         end
         S_MUX: begin
            op_a = MUL_A_W'(r_ff);
            op_b = MUL_B_W'(cfg.tile_w);
         end
         S_MUY: begin
            op_a = q_ff;
            op_b = MUL_B_W'(cfg.tile_h);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // sequencer and datapath
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      cam_x_in    = cam_x_ff;
      cam_y_in    = cam_y_ff;
      color_in    = color_ff;
      id_in       = id_ff;
      fx_in       = fx_ff;
      fy_in       = fy_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      cur_in      = cur_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !out_ready;

      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               cam_x_in = cmd.cam_x;
               cam_y_in = cmd.cam_y;
               color_in = cmd.color;
               pos_in   = '0;
               col_in   = '0;
               row_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rd_data[IDX_W-1]) begin
               // empty entry: skip it
               if (last_pos) begin
                  state_in = S_DONE;
               end else begin
                  pos_in   = pos_ff + WALK_W'(1);
                  if ({1'b0, col_ff} == cfg.across - 4'd1) begin
                     col_in = '0;
                     row_in = row_ff + 3'd1;
                  end else begin
                     col_in = col_ff + 3'd1;
                  end
                  state_in = S_READ;
               end
            end else begin
               id_in    = rd_data[11:0];
               fx_in    = rd_data[IDX_W];
               fy_in    = rd_data[IDX_W+1];
               state_in = S_MSX;
            end
         end
         S_MSX: begin
            state_in = S_MSY;
         end
         S_MSY: begin
            cur_in.screen_x = {cam_x_ff[19], cam_x_ff} + {6'd0, prod[10:0], 4'd0};
            state_in        = S_MQE;
         end
         S_MQE: begin
            cur_in.screen_y = {cam_y_ff[19], cam_y_ff} + {6'd0, prod[10:0], 4'd0};
            state_in        = S_MQA;
         end
         S_MQA: begin
            q_in     = q_est;
            state_in = S_MFIX;
         end
         S_MFIX: begin
            // one correction step of the reciprocal divide
            if (r_raw >= {8'd0, cfg.across}) begin
               r_in = r_fix[2:0];
               q_in = q_ff + 12'd1;
            end else begin
               r_in = r_raw[2:0];
            end
            state_in = S_MUX;
         end
         S_MUX: begin
            state_in = S_MUY;
         end
         S_MUY: begin
            cur_in.uv_x = prod[19:0];
            state_in    = S_MEND;
         end
         S_MEND: begin
            cur_in.uv_y      = prod[19:0];
            cur_in.flip_x    = fx_ff;
            cur_in.flip_y    = fy_ff;
            cur_in.color     = color_ff;
            cur_in.last_tile = 1'b0;
            state_in         = S_PUSH;
         end
         S_PUSH: begin
            // the held result is known not to be last once a newer one exists
            if (!hold_vld_ff || out_free) begin
               if (hold_vld_ff) begin
                  out_in     = hold_ff;
                  out_vld_in = 1'b1;
               end
               hold_in     = cur_ff;
               hold_vld_in = 1'b1;
               if (last_pos) begin
                  state_in = S_DONE;
               end else begin
                  pos_in = pos_ff + WALK_W'(1);
                  if ({1'b0, col_ff} == cfg.across - 4'd1) begin
                     col_in = '0;
                     row_in = row_ff + 3'd1;
                  end else begin
                     col_in = col_ff + 3'd1;
                  end
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            if (!hold_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in           = hold_ff;
               out_in.last_tile = 1'b1;
               out_vld_in       = 1'b1;
               hold_vld_in      = 1'b0;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      cam_x_ff <= cam_x_in;
      cam_y_ff <= cam_y_in;
      color_ff <= color_in;
      id_ff    <= id_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      cur_ff   <= cur_in;
      hold_ff  <= hold_in;
      out_ff   <= out_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign out_valid = out_vld_ff;
   assign out_word  = out_ff;

endmodule

// ===== rtl/core/tilemap_sprite_emitter.sv =====
// Set-tile: taken while idle, ready again the next cycle. Render: each map entry is read;
// empty entries are skipped, a drawn tile makes six passes through one shared multiplier
// and a push; a closing state ends the render. Stalled results hold push and closing states.
// Results leave through an output register; a drawn tile is held one step until the walk
// knows whether it is the last. Reset (synchronous): registers to 8 x 8 tiles of 16 x 16,
// all map entries read as empty at once through per-entry valid bits, no clearing pass.
`timescale 1ns / 1ps

module tilemap_sprite_emitter
   import tse_pkg::*;
#(
   parameter int MAX_TILES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request word
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tile_col, tile_row, tile_index, flip_x, flip_y, camera_x, camera_y, color, zero pad
   input  logic [REQ_W-1:0]      req_tdata,
   // func
   input  logic                  req_tuser,
   // result word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // screen_x, screen_y, uv_x, uv_y, out_flip_x, out_flip_y, out_color, zero pad
   output logic [RSP_W-1:0]      rsp_tdata,
   // last_tile
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [WALK_W-1:0] MaxWalk = WALK_W'(MAX_TILES);

   logic [3:0]        across_ff, across_in;
   logic [3:0]        down_ff, down_in;
   logic [7:0]        tile_w_ff, tile_w_in;
   logic [7:0]        tile_h_ff, tile_h_in;

   logic [3:0]        across_eff;
   logic [3:0]        down_eff;
   logic [WALK_W-1:0] map_size;
   logic [WALK_W-1:0] set_addr;
   logic [2:0]        set_col;
   logic [2:0]        set_row;
   logic              accept;
   logic              idle;
   tse_cfg_type       cfg;
   tse_cmd_type       cmd;
   tse_result_type    res;

   // register writes
   always_comb begin
      across_in = across_ff;
      down_in   = down_ff;
      tile_w_in = tile_w_ff;
      tile_h_in = tile_h_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_TILES_ACROSS: across_in = csr_wdata[3:0];
            CSR_TILES_DOWN:   down_in   = csr_wdata[3:0];
            CSR_TILE_WIDTH:   tile_w_in = csr_wdata;
            CSR_TILE_HEIGHT:  tile_h_in = csr_wdata;
            default:          across_in = across_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         across_ff <= 4'd8;
         down_ff   <= 4'd8;
         tile_w_ff <= 8'd16;
         tile_h_ff <= 8'd16;
      end else begin
         across_ff <= across_in;
         down_ff   <= down_in;
         tile_w_ff <= tile_w_in;
         tile_h_ff <= tile_h_in;
      end
   end

   // map size clamped to 1..8 each way, walk capped at the store depth
   assign across_eff = (across_ff == 4'd0) ? 4'd1 : (across_ff > 4'd8) ? 4'd8 : across_ff;
   assign down_eff   = (down_ff == 4'd0) ? 4'd1 : (down_ff > 4'd8) ? 4'd8 : down_ff;
   assign map_size   = WALK_W'(across_eff) * WALK_W'(down_eff);

   always_comb begin
      cfg.across   = across_eff;
      cfg.walk_len = (map_size < MaxWalk) ? map_size : MaxWalk;
      cfg.tile_w   = tile_w_ff;
      cfg.tile_h   = tile_h_ff;
   end

   // request decode
   assign req_tready = idle;
   assign accept     = req_tvalid && req_tready;
   assign set_col    = req_tdata[2:0];
   assign set_row    = req_tdata[5:3];
   assign set_addr   = WALK_W'(set_row) * WALK_W'(across_eff) + WALK_W'(set_col);

   always_comb begin
      cmd.start   = accept && (req_tuser == FUNC_RENDER);
      cmd.cam_x   = req_tdata[40:21];
      cmd.cam_y   = req_tdata[60:41];
      cmd.color   = req_tdata[92:61];
      // writes outside the map are dropped
      cmd.wr_en   = accept && (req_tuser == FUNC_SET)
                    && ({1'b0, set_col} < across_eff)
                    && ({1'b0, set_row} < down_eff)
                    && (set_addr < cfg.walk_len);
      cmd.wr_addr = set_addr[ADDR_W-1:0];
      cmd.wr_data = {req_tdata[20], req_tdata[19], req_tdata[18:6]};
   end

   tse_walker #(.MAX_TILES(MAX_TILES)) u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .idle      (idle),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_word  (res)
   );

   // result word packing
   assign rsp_tdata = {4'd0, res.color, res.flip_y, res.flip_x, res.uv_y, res.uv_x,
                       res.screen_y, res.screen_x};
   assign rsp_tlast = res.last_tile;

endmodule

// ===== rtl/core/tse_checker.sv =====
// Port-level checks of the tile-map sprite emitter, bound to the top level.
// Depends on tse_pkg and tilemap_sprite_emitter_macros.svh.
`timescale 1ns / 1ps
`include "tilemap_sprite_emitter_macros.svh"

module tse_checker
   import tse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  rsp_tlast
);

   // a stalled result word holds
   `TSE_ASSERT_SAME(a_rsp_hold, clock, reset, $past(rsp_tvalid && !rsp_tready),
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "result word changed while stalled")

   // the request side is ready again right after a set-tile word
   `TSE_ASSERT_NEXT(a_set_one_cycle, clock, reset,
      req_tvalid && req_tready && (req_tuser == FUNC_SET), req_tready,
      "not ready after set-tile")

   // a render keeps the request side closed while it walks
   `TSE_ASSERT_NEXT(a_render_busy, clock, reset,
      req_tvalid && req_tready && (req_tuser == FUNC_RENDER), !req_tready,
      "ready right after render start")

endmodule

bind tilemap_sprite_emitter tse_checker u_tse_checker (.*);

// ===== tb/tilemap_sprite_emitter_checker.sv =====
// Scoreboard for the tile-map sprite emitter: mirrors the tile map and geometry registers,
// expands every accepted render word into the sprites it must draw and checks the results.
// Depends on tse_pkg; instantiated beside the block by tilemap_sprite_emitter_tb.
`timescale 1ns / 1ps

module tilemap_sprite_emitter_checker
   import tse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // tile_col, tile_row, tile_index, flip_x, flip_y, camera_x, camera_y, color, zero pad
   input  logic [REQ_W-1:0]      req_tdata,
   // func
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // screen_x, screen_y, uv_x, uv_y, out_flip_x, out_flip_y, out_color, zero pad
   input  logic [RSP_W-1:0]      rsp_tdata,
   // last_tile
   input  logic                  rsp_tlast,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    sprites_pending
);

   localparam int MAP_SLOTS = 64;

   // mirrored state: map entries {flip_y, flip_x, index} and raw geometry registers
   logic [ENTRY_W-1:0] tile_map [MAP_SLOTS];
   logic [3:0]         map_across;
   logic [3:0]         map_down;
   logic [7:0]         tex_w;
   logic [7:0]         tex_h;
   tse_result_type     sprite_q [$];
   int                 errors;

   // map dimensions are clamped to 1..8
   function automatic int unsigned clamp_dim(input logic [3:0] v);
      if (v == 4'd0) return 1;
      if (v > 4'd8) return 8;
      return v;
   endfunction

   function automatic int unsigned map_walk(input int unsigned a, input int unsigned d);
      return (a * d < MAP_SLOTS) ? a * d : MAP_SLOTS;
   endfunction

   task automatic clear_model();
      int k;
      for (k = 0; k < MAP_SLOTS; k++) tile_map[k] = ENTRY_EMPTY;
      map_across = 4'd8;
      map_down   = 4'd8;
      tex_w      = 8'd16;
      tex_h      = 8'd16;
      errors     = 0;
      sprite_q.delete();
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_TILES_ACROSS: map_across = d[3:0];
         CSR_TILES_DOWN:   map_down   = d[3:0];
         CSR_TILE_WIDTH:   tex_w      = d[7:0];
         CSR_TILE_HEIGHT:  tex_h      = d[7:0];
         default: ;
      endcase
   endtask

   // set-tile: writes outside the clamped map are dropped
   task automatic store_tile(input logic [REQ_W-1:0] w);
      int unsigned a, d, col, row, slot;
      a   = clamp_dim(map_across);
      d   = clamp_dim(map_down);
      col = w[2:0];
      row = w[5:3];
      if (col >= a || row >= d) return;
      slot = row * a + col;
      if (slot >= map_walk(a, d)) return;
      tile_map[slot] = {w[20], w[19], w[18:6]};
   endtask

   // render: one sprite per non-negative entry, last flag on the final one
   task automatic expand_render(input logic [REQ_W-1:0] w);
      int unsigned        a, n, slot, id;
      int                 cam_x, cam_y;
      logic [ENTRY_W-1:0] e;
      tse_result_type     s, held;
      bit                 have_held;
      a         = clamp_dim(map_across);
      n         = map_walk(a, clamp_dim(map_down));
      cam_x     = $signed(w[40:21]);
      cam_y     = $signed(w[60:41]);
      have_held = 1'b0;
      for (slot = 0; slot < n; slot++) begin
         e = tile_map[slot];
         // any negative index, not only -1, leaves the slot blank
         if (e[IDX_W-1]) continue;
         id          = e[IDX_W-1:0];
         s.screen_x  = 21'(cam_x + int'((slot % a) * tex_w * 16));
         s.screen_y  = 21'(cam_y + int'((slot / a) * tex_h * 16));
         s.uv_x      = 20'((id % a) * tex_w);
         s.uv_y      = 20'((id / a) * tex_h);
         s.flip_x    = e[13];
         s.flip_y    = e[14];
         s.color     = w[92:61];
         s.last_tile = 1'b0;
         if (have_held) sprite_q = {sprite_q, held};
         held      = s;
         have_held = 1'b1;
      end
      if (have_held) begin
         held.last_tile = 1'b1;
         sprite_q = {sprite_q, held};
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_sprite(input logic [RSP_W-1:0] w, input logic last);
      tse_result_type want;
      if (sprite_q.size() == 0) begin
         $error("sprite word 0x%h arrived with none expected", w);
         errors++;
         return;
      end
      want = sprite_q.pop_front();
      compare_field("screen_x", want.screen_x, w[20:0]);
      compare_field("screen_y", want.screen_y, w[41:21]);
      compare_field("uv_x", want.uv_x, w[61:42]);
      compare_field("uv_y", want.uv_y, w[81:62]);
      compare_field("out_flip_x", want.flip_x, w[82]);
      compare_field("out_flip_y", want.flip_y, w[83]);
      compare_field("out_color", want.color, w[115:84]);
      compare_field("last_tile", want.last_tile, last);
   endtask

   // results are matched before a request of the same edge is expanded
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_wen) apply_csr(csr_addr, csr_wdata);
         if (rsp_tvalid && rsp_tready) check_sprite(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_RENDER) expand_render(req_tdata);
            else store_tile(req_tdata);
         end
      end
      mismatch_count  <= errors;
      sprites_pending <= sprite_q.size();
   end

endmodule

// ===== tb/tilemap_sprite_emitter_tb.sv =====
// Testbench top for the tile-map sprite emitter: clock, reset, register writes and request
// stimulus with random back-pressure; checking is done by tilemap_sprite_emitter_checker.
// Depends on tse_pkg, tilemap_sprite_emitter and tilemap_sprite_emitter_checker.
`timescale 1ns / 1ps

module tilemap_sprite_emitter_tb;
   import tse_pkg::*;

   localparam int              RANDOM_ITEMS    = 350;
   localparam int              DRAIN_CYCLES    = 160;
   localparam int              RSP_HOLD_CYCLES = 600;
   localparam logic [IDX_W-1:0] IDX_EMPTY      = 13'h1FFF;   // -1
   localparam logic [IDX_W-1:0] IDX_MOST_NEG   = 13'h1000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;    // col, row, index, flip_x, flip_y, cam_x, cam_y, color
   logic                  req_tuser;    // func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;    // scr_x, scr_y, uv_x, uv_y, flip_x, flip_y, color
   logic                  rsp_tlast;    // last_tile
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int sprites_pending;
   bit calm = 1'b0;          // no idling on either side while set
   int holdoffs_asked = 0;
   int holdoffs_done  = 0;

   always #5 clock = ~clock;

   tilemap_sprite_emitter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   tilemap_sprite_emitter_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_wen         (csr_wen),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .sprites_pending (sprites_pending)
   );

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_done != holdoffs_asked) begin
            rsp_tready = 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
            holdoffs_done++;
         end else if (!calm && $urandom_range(99) < 19) begin
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      #25_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [REQ_W-1:0] pack_req(
      input logic [2:0] col, input logic [2:0] row, input logic [IDX_W-1:0] idx,
      input logic fx, input logic fy, input logic [19:0] cx, input logic [19:0] cy,
      input logic [31:0] color);
      return {3'b000, color, cy, cx, fy, fx, idx, row, col};
   endfunction

   function automatic int unsigned map_extent(input logic [7:0] v);
      if (v[3:0] == 4'd0) return 1;
      if (v[3:0] > 4'd8) return 8;
      return v[3:0];
   endfunction

   // dimension write: mostly legal, sometimes zero, too large or with junk upper bits
   function automatic logic [7:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 8'($urandom_range(1, 8));
      if (r < 80) return 8'd0;
      if (r < 92) return 8'($urandom_range(9, 15));
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 8'd0;
      if (r < 25) return 8'd255;
      if (r < 35) return 8'd1;
      return 8'($urandom_range(1, 255));
   endfunction

   // one request word, sometimes with an idle cycle in front of it
   task automatic send_word(input logic func, input logic [REQ_W-1:0] word);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 19) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = func;
      req_tdata  = word;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // unused fields of a set word carry random noise
   task automatic set_tile(input logic [2:0] col, input logic [2:0] row,
                           input logic [IDX_W-1:0] idx, input logic fx, input logic fy);
      send_word(FUNC_SET, pack_req(col, row, idx, fx, fy, 20'($urandom), 20'($urandom),
                                   $urandom));
   endtask

   task automatic render(input logic [19:0] cx, input logic [19:0] cy, input logic [31:0] color);
      send_word(FUNC_RENDER, pack_req(3'($urandom), 3'($urandom), 13'($urandom),
                                      1'($urandom), 1'($urandom), cx, cy, color));
   endtask

   // wait until every sprite is out and the walker has had time to finish
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sprites_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_geometry(input logic [7:0] across, input logic [7:0] down,
                                input logic [7:0] tw, input logic [7:0] th);
      settle();
      csr_wen   = 1'b1;
      csr_addr  = CSR_TILES_ACROSS;
      csr_wdata = across;
      @(negedge clock);
      csr_addr  = CSR_TILES_DOWN;
      csr_wdata = down;
      @(negedge clock);
      csr_addr  = CSR_TILE_WIDTH;
      csr_wdata = tw;
      @(negedge clock);
      csr_addr  = CSR_TILE_HEIGHT;
      csr_wdata = th;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   initial begin
      int               sent, phase, nfill, nren, r, ext_a, ext_d;
      logic [7:0]       g_a, g_d, g_w, g_h;
      logic [2:0]       col, row;
      logic [IDX_W-1:0] idx;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_SET;
      csr_wen    = 1'b0;
      csr_addr   = CSR_TILES_ACROSS;
      csr_wdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty map, corner entries, flips, negative indexes, extreme cameras
      render(20'h0, 20'h0, 32'h0);
      set_tile(3'd0, 3'd0, 13'd0, 1'b0, 1'b0);
      set_tile(3'd7, 3'd7, 13'd4095, 1'b1, 1'b1);
      set_tile(3'd1, 3'd0, 13'h1FFE, 1'b1, 1'b0);      // -2 is kept but not drawn
      set_tile(3'd2, 3'd0, 13'd100, 1'b0, 1'b1);
      set_tile(3'd2, 3'd0, IDX_EMPTY, 1'b0, 1'b0);     // cleared again
      set_tile(3'd5, 3'd3, IDX_MOST_NEG, 1'b1, 1'b1);
      set_tile(3'd6, 3'd3, 13'd2047, 1'b0, 1'b1);
      render(20'h7FFFF, 20'h7FFFF, 32'hFFFF_FFFF);
      render(20'h80000, 20'h80000, 32'h0000_0000);
      render(20'($urandom), 20'($urandom), $urandom);

      // clamped geometry, zero tile width: entries reappear at new positions
      load_geometry(8'd0, 8'd15, 8'd0, 8'd255);
      set_tile(3'd3, 3'd0, 13'd5, 1'b0, 1'b0);         // outside one-column map
      set_tile(3'd0, 3'd5, 13'd77, 1'b1, 1'b0);
      render(20'h12345, 20'hFEDCB, 32'hA5A5_5A5A);

      load_geometry(8'd3, 8'd3, 8'd255, 8'd0);
      set_tile(3'd2, 3'd2, 13'd4095, 1'b0, 1'b0);
      set_tile(3'd0, 3'd3, 13'd9, 1'b1, 1'b1);         // row outside
      set_tile(3'd3, 3'd1, 13'd9, 1'b1, 1'b1);         // column outside
      render(20'($urandom), 20'($urandom), $urandom);

      load_geometry(8'd8, 8'd8, 8'd255, 8'd255);
      render(20'h7FFFF, 20'h7FFFF, $urandom);
      render(20'h80000, 20'h80000, $urandom);

      // random phases: new geometry, a batch of tile writes, then a few renders
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            1: begin
               g_a = 8'd1; g_d = 8'd1; g_w = 8'd1; g_h = 8'd1;
            end
            2: begin
               g_a = 8'd8; g_d = 8'd8; g_w = 8'd255; g_h = 8'd255;
            end
            default: begin
               g_a = pick_dim(); g_d = pick_dim(); g_w = pick_size(); g_h = pick_size();
            end
         endcase
         load_geometry(g_a, g_d, g_w, g_h);
         calm  = (phase == 4 || phase == 5);
         ext_a = map_extent(g_a);
         ext_d = map_extent(g_d);

         nfill = (phase == 2) ? 40 : $urandom_range(3, 20);
         repeat (nfill) begin
            r = $urandom_range(99);
            if (r < 65) idx = 13'($urandom_range(4095));
            else if (r < 80) idx = IDX_EMPTY;
            else if (r < 90) idx = {1'b1, 12'($urandom)};
            else idx = 13'($urandom);
            if ($urandom_range(99) < 85) begin
               col = 3'($urandom_range(ext_a - 1));
               row = 3'($urandom_range(ext_d - 1));
            end else begin
               col = 3'($urandom);
               row = 3'($urandom);
            end
            set_tile(col, row, idx, 1'($urandom), 1'($urandom));
            sent++;
         end

         // one phase keeps the result side stalled while renders pile up
         nren = (phase == 2) ? 3 : $urandom_range(1, 3);
         if (phase == 2) holdoffs_asked++;
         repeat (nren) begin
            render(20'($urandom), 20'($urandom), $urandom);
            sent++;
         end
         phase++;
      end

      calm = 1'b0;
      settle();
      if (mismatch_count == 0 && sprites_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tse_pkg.sv
rtl/core/tse_store.sv
rtl/core/tse_mul.sv
rtl/core/tse_walker.sv
rtl/core/tilemap_sprite_emitter.sv
rtl/core/tse_checker.sv
tb/tilemap_sprite_emitter_checker.sv
tb/tilemap_sprite_emitter_tb.sv
